// ----- rtl/dapm_pkg.sv -----
package dapm_pkg;

  localparam int ROLL_INT_LIMIT  = 40;
  localparam int PITCH_INT_LIMIT = 80;
  localparam int DERIV_SETPOINT  = 0;
  localparam int SAMPLE_PERIOD   = 62;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int EN_W      = 2;

  localparam int ERR_W  = IN_W + 1;
  localparam int DX_W   = 26;
  localparam int GAIN_W = 17;
  localparam int PROD_W = DX_W + GAIN_W;
  localparam int ISUM_W = PROD_W + 1;
  localparam int CMD_W  = 50;
  localparam int CMDC_W = 18;
  localparam int MIX_W  = 12;

  localparam int DOFS = DERIV_SETPOINT * 256 * SAMPLE_PERIOD;

  localparam int DIV_D      = 2 * SAMPLE_PERIOD;
  localparam int DIV_DW     = $clog2(DIV_D);
  localparam int DIV_RW     = DIV_DW + 4;
  localparam int DIV_K      = 44 - DIV_DW;
  localparam int DIV_NW     = 48;
  localparam int DIV_SW     = DIV_NW + 1;
  localparam int DIV_DIGITS = DIV_NW / 4;
  localparam int DIV_CW     = $clog2(DIV_DIGITS);
  localparam longint DIV_BIAS = longint'(DIV_D) << DIV_K;
  localparam longint DIV_QOFS = longint'(1) << DIV_K;

  localparam int CMD_MAX     = 65536;
  localparam int SERVO_SCALE = 500;
  localparam int SERVO_ROUND = 32768;
  localparam int SERVO_MID   = 1500;
  localparam int MIX_CENTER  = 1550;
  localparam int PULSE_MIN   = 1000;
  localparam int PULSE_MAX   = 2000;
  localparam int TRIM_RST    = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_KP,
    REG_ROLL_KI,
    REG_ROLL_KD,
    REG_PITCH_KP,
    REG_PITCH_KI,
    REG_PITCH_KD,
    REG_PITCH_TRIM,
    REG_TERM_EN
  } cfg_reg_e;

  typedef enum logic [0:0] {
    AXIS_ROLL,
    AXIS_PITCH
  } axis_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_IADD,
    OP_DIV_STEP,
    OP_DADD,
    OP_MUL_S,
    OP_SERVO,
    OP_MIX
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_IADD,
    ST_DIV,
    ST_DADD,
    ST_MUL_S,
    ST_SERVO,
    ST_MIX
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    axis_e  axis;
  } dp_cmd_t;

  typedef struct packed {
    logic        [CFG_W-1:0] roll_prop_gain;
    logic        [CFG_W-1:0] roll_int_gain;
    logic        [CFG_W-1:0] roll_deriv_gain;
    logic        [CFG_W-1:0] pitch_prop_gain;
    logic        [CFG_W-1:0] pitch_int_gain;
    logic        [CFG_W-1:0] pitch_deriv_gain;
    logic signed [CFG_W-1:0] pitch_trim;
    logic        [EN_W-1:0]  term_enables;
  } cfg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] roll_target;
    logic signed [IN_W-1:0] pitch_target;
    logic signed [IN_W-1:0] roll_measured;
    logic signed [IN_W-1:0] pitch_measured;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] left_pulse_us;
    logic [OUT_W-1:0] right_pulse_us;
  } out_item_t;

endpackage

// ----- rtl/dapm_if.sv -----
interface dapm_in_if;
  import dapm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dapm_out_if;
  import dapm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dapm_cfg.sv -----
module dapm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dapm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dapm_pkg::CFG_W-1:0]         cfg_data_i,
  output dapm_pkg::cfg_t                     cfg_o
);
  import dapm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROLL_KP:    cfg_d.roll_prop_gain   = cfg_data_i;
        REG_ROLL_KI:    cfg_d.roll_int_gain    = cfg_data_i;
        REG_ROLL_KD:    cfg_d.roll_deriv_gain  = cfg_data_i;
        REG_PITCH_KP:   cfg_d.pitch_prop_gain  = cfg_data_i;
        REG_PITCH_KI:   cfg_d.pitch_int_gain   = cfg_data_i;
        REG_PITCH_KD:   cfg_d.pitch_deriv_gain = cfg_data_i;
        REG_PITCH_TRIM: cfg_d.pitch_trim       = $signed(cfg_data_i);
        REG_TERM_EN:    cfg_d.term_enables     = cfg_data_i[EN_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pitch_trim: CFG_W'(TRIM_RST), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dapm_ctrl.sv -----
module dapm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dapm_pkg::dp_cmd_t cmd_o
);
  import dapm_pkg::*;

  ctrl_state_e       state_q, state_d;
  axis_e             axis_q, axis_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  dp_op_e            op;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    op          = OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op      = OP_LOAD;
          axis_d  = AXIS_ROLL;
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        op      = OP_MUL_P;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        op      = OP_MUL_I;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        op      = OP_MUL_D;
        state_d = ST_IADD;
      end
      ST_IADD: begin
        op      = OP_IADD;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        op    = OP_DIV_STEP;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_DIGITS - 1)) begin
          state_d = ST_DADD;
        end
      end
      ST_DADD: begin
        op      = OP_DADD;
        state_d = ST_MUL_S;
      end
      ST_MUL_S: begin
        op      = OP_MUL_S;
        state_d = ST_SERVO;
      end
      ST_SERVO: begin
        op = OP_SERVO;
        if (axis_q == AXIS_ROLL) begin
          axis_d  = AXIS_PITCH;
          state_d = ST_MUL_P;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!out_valid_q || out_ready_i) begin
          op          = OP_MIX;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_ROLL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;
  assign cmd_o.axis  = axis_q;

endmodule

// ----- rtl/dapm_dp.sv -----
module dapm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dapm_pkg::dp_cmd_t    cmd_i,
  input  dapm_pkg::cfg_t       cfg_i,
  input  dapm_pkg::in_item_t   in_data_i,
  output dapm_pkg::out_item_t  out_data_o
);
  import dapm_pkg::*;

  // per-axis state and operands
  logic signed [IN_W-1:0]   integ_q [2];
  logic signed [IN_W-1:0]   integ_d [2];
  logic signed [IN_W-1:0]   prev_q [2];
  logic signed [IN_W-1:0]   prev_d [2];
  logic signed [ERR_W-1:0]  err_q [2];
  logic signed [ERR_W-1:0]  err_d [2];
  logic signed [DX_W-1:0]   dx_q [2];
  logic signed [DX_W-1:0]   dx_d [2];
  logic        [OUT_W-1:0]  us_q [2];
  logic        [OUT_W-1:0]  us_d [2];

  logic signed [IN_W-1:0]   acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [CMD_W-1:0]  cmd_q, cmd_d;
  logic        [DIV_NW-1:0] dvd_q, dvd_d;
  logic        [DIV_DW-1:0] rem_q, rem_d;
  out_item_t                out_q, out_d;

  logic signed [DX_W-1:0]   mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  axis_e ax;
  assign ax = cmd_i.axis;

  // shared multiplier
  always_comb begin
    mul_a = DX_W'(err_q[ax]);
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_P: mul_b = (ax == AXIS_PITCH) ? $signed({1'b0, cfg_i.pitch_prop_gain})
                                           : $signed({1'b0, cfg_i.roll_prop_gain});
      OP_MUL_I: mul_b = (ax == AXIS_PITCH) ? $signed({1'b0, cfg_i.pitch_int_gain})
                                           : $signed({1'b0, cfg_i.roll_int_gain});
      OP_MUL_D: begin
        mul_a = dx_q[ax];
        mul_b = (ax == AXIS_PITCH) ? $signed({1'b0, cfg_i.pitch_deriv_gain})
                                   : $signed({1'b0, cfg_i.roll_deriv_gain});
      end
      OP_MUL_S: begin
        mul_a = DX_W'($signed(cmd_q[CMDC_W-1:0]));
        mul_b = GAIN_W'(SERVO_SCALE);
      end
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic signed [CMD_W-1:0]  trim_ext;
  logic signed [CMD_W-1:0]  dterm;
  logic signed [CMD_W-1:0]  csum;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [ISUM_W-1:0] iclp;
  logic signed [DIV_SW-1:0] dsum;
  logic        [DIV_RW-1:0] nw;
  logic        [DIV_RW-1:0] rsub;
  logic        [3:0]        dig;
  logic signed [PROD_W-1:0] ssum;
  logic signed [PROD_W-1:0] srv;
  logic        [MIX_W-1:0]  lsum;
  logic        [MIX_W-1:0]  rsum;

  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    err_d   = err_q;
    dx_d    = dx_q;
    us_d    = us_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    cmd_d   = cmd_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    out_d   = out_q;

    trim_ext = (ax == AXIS_PITCH) ? (CMD_W'(cfg_i.pitch_trim) <<< 8) : '0;
    dterm    = CMD_W'($signed({1'b0, dvd_q})) - CMD_W'(DIV_QOFS);
    csum     = cmd_q + (cfg_i.term_enables[1] ? dterm : '0);

    isum = ((ISUM_W'(integ_q[ax]) <<< 8) + ISUM_W'(prod_q) + ISUM_W'(128)) >>> 8;
    ilim = (ax == AXIS_PITCH) ? ISUM_W'(PITCH_INT_LIMIT * 256)
                              : ISUM_W'(ROLL_INT_LIMIT * 256);
    if (isum > ilim) begin
      iclp = ilim;
    end else if (isum < -ilim) begin
      iclp = -ilim;
    end else begin
      iclp = isum;
    end

    dsum = (DIV_SW'(prod_q) <<< 1) + DIV_SW'(SAMPLE_PERIOD) + DIV_SW'(DIV_BIAS);

    // one radix-16 quotient digit
    nw   = {rem_q, dvd_q[DIV_NW-1 -: 4]};
    dig  = '0;
    rsub = nw;
    for (int k = 1; k < 16; k++) begin
      if (nw >= DIV_RW'(DIV_D * k)) begin
        dig  = 4'(k);
        rsub = nw - DIV_RW'(DIV_D * k);
      end
    end

    ssum = prod_q + PROD_W'(SERVO_ROUND);
    srv  = (ssum >>> 16) + PROD_W'(SERVO_MID);

    lsum = MIX_W'(us_q[AXIS_PITCH]) + MIX_W'(us_q[AXIS_ROLL]) - MIX_W'(MIX_CENTER);
    rsum = MIX_W'(us_q[AXIS_ROLL]) + MIX_W'(MIX_CENTER) - MIX_W'(us_q[AXIS_PITCH]);

    case (cmd_i.op)
      OP_LOAD: begin
        err_d[AXIS_ROLL]  = ERR_W'(in_data_i.roll_target) - ERR_W'(in_data_i.roll_measured);
        err_d[AXIS_PITCH] = ERR_W'(in_data_i.pitch_target)
                          - ERR_W'(in_data_i.pitch_measured);
        dx_d[AXIS_ROLL]   = DX_W'(DOFS) - DX_W'(prev_q[AXIS_ROLL])
                          + DX_W'(in_data_i.roll_measured);
        dx_d[AXIS_PITCH]  = DX_W'(DOFS) - DX_W'(prev_q[AXIS_PITCH])
                          + DX_W'(in_data_i.pitch_measured);
        prev_d[AXIS_ROLL]  = in_data_i.roll_measured;
        prev_d[AXIS_PITCH] = in_data_i.pitch_measured;
      end
      OP_MUL_P: prod_d = mul_p;
      OP_MUL_I: begin
        cmd_d  = CMD_W'(prod_q) + trim_ext;
        prod_d = mul_p;
      end
      OP_MUL_D: begin
        integ_d[ax] = iclp[IN_W-1:0];
        acc_d       = iclp[IN_W-1:0];
        prod_d      = mul_p;
      end
      OP_IADD: begin
        cmd_d = cmd_q + (cfg_i.term_enables[0] ? (CMD_W'(acc_q) <<< 8) : '0);
        dvd_d = dsum[DIV_NW-1:0];
        rem_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = rsub[DIV_DW-1:0];
        dvd_d = {dvd_q[DIV_NW-5:0], dig};
      end
      OP_DADD: begin
        if (csum > CMD_W'(CMD_MAX)) begin
          cmd_d = CMD_W'(CMD_MAX);
        end else if (csum < -CMD_W'(CMD_MAX)) begin
          cmd_d = -CMD_W'(CMD_MAX);
        end else begin
          cmd_d = csum;
        end
      end
      OP_MUL_S: prod_d = mul_p;
      OP_SERVO: us_d[ax] = srv[OUT_W-1:0];
      OP_MIX: begin
        if (lsum < MIX_W'(PULSE_MIN)) begin
          out_d.left_pulse_us = OUT_W'(PULSE_MIN);
        end else if (lsum > MIX_W'(PULSE_MAX)) begin
          out_d.left_pulse_us = OUT_W'(PULSE_MAX);
        end else begin
          out_d.left_pulse_us = lsum[OUT_W-1:0];
        end
        if (rsum < MIX_W'(PULSE_MIN)) begin
          out_d.right_pulse_us = OUT_W'(PULSE_MIN);
        end else if (rsum > MIX_W'(PULSE_MAX)) begin
          out_d.right_pulse_us = OUT_W'(PULSE_MAX);
        end else begin
          out_d.right_pulse_us = rsum[OUT_W-1:0];
        end
      end
      default: prod_d = prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '{default: '0};
      prev_q  <= '{default: '0};
    end else begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    dx_q   <= dx_d;
    us_q   <= us_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    cmd_q  <= cmd_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/dual_axis_pid_elevon_mixer.sv -----
// channel   dir  handshake      payload
// in_i      in   valid/ready    roll/pitch target and measured, signed q8.8
// out_o     out  valid/ready    left/right pulse width in us, 1000..2000
// cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_data_i 16 bit
//
// an item runs through the idle state that takes the transfer, then for each axis
// four passes through the one shared multiplier, twelve radix-16 digit steps of
// the derivative divider and three adds, and last the mix step
// reset clears gains, integrators, last measurements and enables, and sets pitch trim to 26
// a result stalled on out_o does not block the next input; only the mix step waits
module dual_axis_pid_elevon_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dapm_in_if.sink                         in_i,
  dapm_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [dapm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dapm_pkg::CFG_W-1:0]      cfg_data_i
);
  import dapm_pkg::*;

  cfg_t      cfg;
  dp_cmd_t   cmd;
  out_item_t out_data;
  logic      in_ready;
  logic      out_valid;

  dapm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dapm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dapm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (in_i.data),
    .out_data_o (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

// ----- rtl/dapm_checker.sv -----
module dapm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [dapm_pkg::OUT_W-1:0] out_left_i,
  input logic [dapm_pkg::OUT_W-1:0] out_right_i
);
  import dapm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_left_i) && $stable(out_right_i))
    else $error("result changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_left_i >= OUT_W'(PULSE_MIN) && out_left_i <= OUT_W'(PULSE_MAX)
                 && out_right_i >= OUT_W'(PULSE_MIN) && out_right_i <= OUT_W'(PULSE_MAX))
    else $error("pulse width out of range");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while item in progress");

endmodule

bind dual_axis_pid_elevon_mixer dapm_checker u_dapm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.data.left_pulse_us),
  .out_right_i (out_o.data.right_pulse_us)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dapm_pkg::*;

  localparam longint ROLL_LIM    = 40;
  localparam longint PITCH_LIM   = 80;
  localparam longint D_SETPOINT  = 0;
  localparam longint T_SAMPLE    = 62;
  localparam longint CMD_FULL    = 65536;
  localparam longint US_MID      = 1500;
  localparam longint MIX_MID     = 1550;
  localparam longint US_MIN      = 1000;
  localparam longint US_MAX      = 2000;
  localparam int     TRIM_RESET  = 26;
  localparam int     LONG_HOLD   = 400;
  localparam int     QUIET_LIMIT = 4000;

  class pulse_scoreboard;
    cfg_t               gains;
    logic signed [15:0] roll_integ;
    logic signed [15:0] pitch_integ;
    logic signed [15:0] roll_last;
    logic signed [15:0] pitch_last;
    out_item_t          pending_pulses[$];
    int                 n_errors;
    int                 n_checked;

    function new();
      gains            = '0;
      gains.pitch_trim = 16'(TRIM_RESET);
      roll_integ       = '0;
      pitch_integ      = '0;
      roll_last        = '0;
      pitch_last       = '0;
      n_errors         = 0;
      n_checked        = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        REG_ROLL_KP:    gains.roll_prop_gain   = val;
        REG_ROLL_KI:    gains.roll_int_gain    = val;
        REG_ROLL_KD:    gains.roll_deriv_gain  = val;
        REG_PITCH_KP:   gains.pitch_prop_gain  = val;
        REG_PITCH_KI:   gains.pitch_int_gain   = val;
        REG_PITCH_KD:   gains.pitch_deriv_gain = val;
        REG_PITCH_TRIM: gains.pitch_trim       = val;
        REG_TERM_EN:    gains.term_enables     = val[1:0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint axis_pulse_us(longint tgt, longint meas, longint kp, longint ki,
                                   longint kd, longint lim, longint trim,
                                   inout logic signed [15:0] integ,
                                   inout logic signed [15:0] last);
      longint err, pterm, inc, acc, num, dterm, cmd;
      err   = tgt - meas;
      pterm = err * kp;
      inc   = floor_div(err * ki + 128, 256);
      acc   = clamp(longint'(integ) + inc, -lim * 256, lim * 256);
      num   = (D_SETPOINT * 256 * T_SAMPLE - (longint'(last) - meas)) * kd;
      dterm = floor_div(2 * num + T_SAMPLE, 2 * T_SAMPLE);
      integ = 16'(acc);
      last  = 16'(meas);
      cmd   = pterm + trim * 256;
      if (gains.term_enables[0]) cmd += acc * 256;
      if (gains.term_enables[1]) cmd += dterm;
      cmd = clamp(cmd, -CMD_FULL, CMD_FULL);
      return US_MID + floor_div(cmd * 500 + 32768, CMD_FULL);
    endfunction

    function void note_tick(in_item_t t);
      longint    roll_us, pitch_us;
      out_item_t p;
      roll_us  = axis_pulse_us(longint'($signed(t.roll_target)),
                               longint'($signed(t.roll_measured)),
                               longint'(gains.roll_prop_gain), longint'(gains.roll_int_gain),
                               longint'(gains.roll_deriv_gain), ROLL_LIM, 0,
                               roll_integ, roll_last);
      pitch_us = axis_pulse_us(longint'($signed(t.pitch_target)),
                               longint'($signed(t.pitch_measured)),
                               longint'(gains.pitch_prop_gain), longint'(gains.pitch_int_gain),
                               longint'(gains.pitch_deriv_gain), PITCH_LIM,
                               longint'($signed(gains.pitch_trim)),
                               pitch_integ, pitch_last);
      p.left_pulse_us  = 11'(clamp(pitch_us - MIX_MID + roll_us, US_MIN, US_MAX));
      p.right_pulse_us = 11'(clamp(MIX_MID - pitch_us + roll_us, US_MIN, US_MAX));
      pending_pulses.push_back(p);
    endfunction

    function void check_pulses(out_item_t got);
      out_item_t want;
      n_checked++;
      if (pending_pulses.size() == 0) begin
        n_errors++;
        $error("pulse pair %0d/%0d with no tick pending", got.left_pulse_us,
               got.right_pulse_us);
        return;
      end
      want = pending_pulses.pop_front();
      if (got.left_pulse_us !== want.left_pulse_us) begin
        n_errors++;
        $error("left_pulse_us: expected %0d, got %0d", want.left_pulse_us, got.left_pulse_us);
      end
      if (got.right_pulse_us !== want.right_pulse_us) begin
        n_errors++;
        $error("right_pulse_us: expected %0d, got %0d", want.right_pulse_us,
               got.right_pulse_us);
      end
    endfunction

    function int pending();
      return pending_pulses.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  dapm_in_if  in_bus ();
  dapm_out_if out_bus ();

  pulse_scoreboard sb = new();

  bit idling   = 1'b1;
  bit hold_req = 1'b0;
  int n_ticks    = 0;
  int n_settings = 0;
  int n_holds    = 0;
  int quiet_cycles;

  dual_axis_pid_elevon_mixer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic in_item_t make_tick(int rt, int pt, int rm, int pm);
    in_item_t t;
    t.roll_target    = 16'(rt);
    t.pitch_target   = 16'(pt);
    t.roll_measured  = 16'(rm);
    t.pitch_measured = 16'(pm);
    return t;
  endfunction

  function automatic in_item_t pick_tick(bit wide);
    in_item_t t;
    if (wide) begin
      t = make_tick($urandom, $urandom, $urandom, $urandom);
    end else begin
      t = make_tick($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
    end
    return t;
  endfunction

  function automatic cfg_t uniform_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                         logic signed [15:0] trim, logic [1:0] en);
    cfg_t c;
    c.roll_prop_gain   = kp;
    c.roll_int_gain    = ki;
    c.roll_deriv_gain  = kd;
    c.pitch_prop_gain  = kp;
    c.pitch_int_gain   = ki;
    c.pitch_deriv_gain = kd;
    c.pitch_trim       = trim;
    c.term_enables     = en;
    return c;
  endfunction

  function automatic cfg_t pick_gains(int style);
    cfg_t c;
    case (style)
      0: begin
        c.roll_prop_gain   = 16'($urandom_range(0, 1023));
        c.roll_int_gain    = 16'($urandom_range(0, 63));
        c.roll_deriv_gain  = 16'($urandom_range(0, 1023));
        c.pitch_prop_gain  = 16'($urandom_range(0, 1023));
        c.pitch_int_gain   = 16'($urandom_range(0, 63));
        c.pitch_deriv_gain = 16'($urandom_range(0, 1023));
        c.pitch_trim       = 16'($urandom_range(0, 1023) - 512);
        c.term_enables     = 2'($urandom_range(0, 3));
      end
      1: c = uniform_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 2'b11);
      2: c = uniform_gains(16'h0000, 16'h0000, 16'h0000, 16'sh8000, 2'($urandom_range(0, 3)));
      default: begin
        c = uniform_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          2'($urandom_range(0, 3)));
        c.pitch_prop_gain  = 16'($urandom);
        c.pitch_int_gain   = 16'($urandom);
        c.pitch_deriv_gain = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  task automatic cfg_write(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(cfg_t c);
    cfg_write(REG_ROLL_KP, c.roll_prop_gain);
    cfg_write(REG_ROLL_KI, c.roll_int_gain);
    cfg_write(REG_ROLL_KD, c.roll_deriv_gain);
    cfg_write(REG_PITCH_KP, c.pitch_prop_gain);
    cfg_write(REG_PITCH_KI, c.pitch_int_gain);
    cfg_write(REG_PITCH_KD, c.pitch_deriv_gain);
    cfg_write(REG_PITCH_TRIM, c.pitch_trim);
    // upper bits of the enable write carry junk
    cfg_write(REG_TERM_EN, {14'($urandom), c.term_enables});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_tick(in_item_t t);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= t;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_tick(t);
    n_ticks++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side
  initial begin
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else if (idling && $urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) sb.check_pulses(out_bus.data);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int ph;
    int i;
    int style;
    rst_ni       <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_ROLL_KP;
    cfg_data_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero gains, default trim
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(32767, 32767, -32768, -32768));
    send_tick(make_tick(-32768, -32768, 32767, 32767));

    // integral and last measurement keep running with terms off
    drain();
    apply_config(uniform_gains(256, 4, 256, 0, 2'b00));
    repeat (3) send_tick(make_tick(2560, -2560, 0, 0));
    drain();
    apply_config(uniform_gains(256, 4, 256, 0, 2'b01));
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(512, -512, 0, 0));
    drain();
    apply_config(uniform_gains(256, 4, 256, 0, 2'b10));
    send_tick(make_tick(0, 0, 1024, -1024));
    send_tick(make_tick(0, 0, -1024, 1024));
    send_tick(make_tick(0, 0, -1024, 1024));
    drain();
    apply_config(uniform_gains(256, 4, 256, -200, 2'b11));
    send_tick(make_tick(300, -300, 100, 50));
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(-300, 300, -100, -50));

    // saturation at full gains and trim extremes
    drain();
    apply_config(uniform_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 2'b11));
    send_tick(make_tick(32767, -32768, -32768, 32767));
    send_tick(make_tick(-32768, 32767, 32767, -32768));
    send_tick(make_tick(0, 0, 0, 0));
    drain();
    apply_config(uniform_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 2'b11));
    send_tick(make_tick(32767, 32767, -32768, -32768));
    send_tick(make_tick(-32768, -32768, 32767, 32767));
    send_tick(make_tick(0, 0, 0, 0));

    for (ph = 0; ph < 12; ph++) begin
      drain();
      case (ph)
        0:       style = 1;
        1:       style = 2;
        2, 7:    style = 3;
        default: style = 0;
      endcase
      apply_config(pick_gains(style));
      if (ph == 3) hold_req = 1'b1;
      if (ph >= 10) idling = 1'b0;
      for (i = 0; i < 100; i++) begin
        if (ph == 5 && i == 50) drain();
        send_tick(pick_tick($urandom_range(0, 6) == 0));
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d control ticks over %0d register settings, %0d long output stall(s)",
             n_ticks, n_settings, n_holds);
    $display("%0d pulse pairs checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
